FILE: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRIO_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int FILL_W   = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // Request codes
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    req_type_t            req_type;
    logic signed [31:0]   item_value;
    logic        [7:0]    item_priority;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic signed [31:0]   out_value;
    logic        [7:0]    out_priority;
    logic        [4:0]    fill_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request on an input transfer
    logic exec;   // apply the request and load the result register
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: captures one request, executes it when the result register is
// free, and tracks the output valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and result flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register must be empty or draining this cycle
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Compare-and-shift slot array with request and result registers.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  in_item_t                req;
  logic [VALUE_W-1:0]      slot_val [CAPACITY];
  logic [PRIO_W-1:0]       slot_pri [CAPACITY];
  logic [VALUE_W-1:0]      slot_val_next [CAPACITY];
  logic [PRIO_W-1:0]       slot_pri_next [CAPACITY];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [PRIO_W-1:0]       req_pri;
  logic [CAPACITY-1:0]     keep;
  logic [CAPACITY-1:0]     keep_prev;
  logic                    full;
  logic                    empty;
  out_item_t               result;

  assign req_pri = PRIO_W'(req.item_priority);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);

  // Slot i stays put when it holds an entry of equal or higher priority
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (CNT_W'(i) < count) && (slot_pri[i] >= req_pri);
    end
  end
  assign keep_prev = {keep[CAPACITY-2:0], 1'b1};

  // Next slot contents, entry count and result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_val_next[i] = slot_val[i];
      slot_pri_next[i] = slot_pri[i];
    end
    count_next          = count;
    result.status       = ST_DONE;
    result.out_value    = '0;
    result.out_priority = '0;
    if (req.req_type == REQ_INSERT) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!keep[i]) begin
            if (keep_prev[i]) begin
              slot_val_next[i] = req.item_value;
              slot_pri_next[i] = req_pri;
            end else begin
              slot_val_next[i] = slot_val[IDX_W'((i == 0) ? 0 : i - 1)];
              slot_pri_next[i] = slot_pri[IDX_W'((i == 0) ? 0 : i - 1)];
            end
          end
        end
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        result.status = ST_EMPTY;
      end else begin
        result.out_value    = slot_val[0];
        result.out_priority = 8'(slot_pri[0]);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          slot_val_next[i] = slot_val[IDX_W'(i + 1)];
          slot_pri_next[i] = slot_pri[IDX_W'(i + 1)];
        end
        count_next = count - 1'b1;
      end
    end
    result.fill_count = FILL_W'(count_next);
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Request, slots and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.exec) begin
      out_data <= result;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_val[i] <= slot_val_next[i];
        slot_pri[i] <= slot_pri_next[i];
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.req_type == REQ_INSERT && !full)
      |=> (count == $past(count) + 1'b1) && (out_data.status == ST_DONE))
    else $error("accepted insert did not add an entry");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.req_type == REQ_INSERT && full)
      |=> $stable(count) && (out_data.status == ST_FULL))
    else $error("insert on full queue changed state");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.req_type == REQ_REMOVE && count > CNT_W'(1))
      |=> (out_data.out_priority >= 8'(slot_pri[0])))
    else $error("removed entry ranks below new head");

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of 16 entries kept sorted, highest priority first.
// ----------------------------------------------------------------------------
// Each request (insert or remove) yields one result. A request is first
// captured in the request register; then the compare-and-shift slot array
// updates all slots in parallel and loads the result register; the next
// request is taken while the result waits in that register. Inserts go behind
// all entries of equal or higher priority. Insert on a full queue and remove
// on an empty one leave the queue unchanged and report it in status.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: dv/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker
// Watches both channels of the queue, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Every input transfer runs through a private copy of the sorted slot array.
// The predicted result goes to a FIFO. Every output transfer is compared field
// by field against the oldest entry in that FIFO. The mismatch count and the
// number of results still outstanding go back to the testbench top.
module sorted_priority_queue_checker
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int MAX_REPORTS = 10;

  // Private copy of the queue contents, highest priority in slot 0
  logic signed [VALUE_W-1:0] slot_val [CAPACITY];
  logic        [PRIO_W-1:0]  slot_pri [CAPACITY];
  int                        fill;

  out_item_t expected_results [$];
  int        mismatch_count = 0;
  int        result_index   = 0;

  // Apply one request to the copy and return the result it should produce
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    int        pos;
    int        i;
    res        = '0;
    res.status = ST_DONE;
    if (req.req_type == REQ_INSERT) begin
      if (fill >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < fill && slot_pri[pos] >= req.item_priority) pos++;
        for (i = fill; i > pos; i--) begin
          slot_val[i] = slot_val[i-1];
          slot_pri[i] = slot_pri[i-1];
        end
        slot_val[pos] = req.item_value;
        slot_pri[pos] = req.item_priority;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_value    = slot_val[0];
        res.out_priority = slot_pri[0];
        for (i = 0; i + 1 < fill; i++) begin
          slot_val[i] = slot_val[i+1];
          slot_pri[i] = slot_pri[i+1];
        end
        fill--;
      end
    end
    res.fill_count = FILL_W'(fill);
    return res;
  endfunction

  // Compare output transfers first, then record the new request
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      expected_results.delete();
      fill = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] #%0d unexpected: st %0d val %0d pri %0d fill %0d",
                     $realtime, result_index, out_data.status, out_data.out_value,
                     out_data.out_priority, out_data.fill_count);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.out_value !== want.out_value ||
              out_data.out_priority !== want.out_priority ||
              out_data.fill_count !== want.fill_count) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("[%0t] #%0d exp/got: st %0d/%0d val %0d/%0d pri %0d/%0d fill %0d/%0d",
                       $realtime, result_index, want.status, out_data.status,
                       want.out_value, out_data.out_value, want.out_priority,
                       out_data.out_priority, want.fill_count, out_data.fill_count);
          end
        end
        result_index++;
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(in_data));
    end
    fail_count <= mismatch_count;
    pending    <= expected_results.size();
  end

endmodule

FILE: dv/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Stimulus and verdict for the sorted priority queue.
// ----------------------------------------------------------------------------
// A short directed sequence covers empty removes, priority and value extremes,
// ties that must leave in arrival order and a refused insert on a full queue.
// Random phases then lean toward filling, draining or balance, with priority
// spreads from wide to heavily tied. Both channels idle at random, and the
// receiver at least once holds off long enough for the queue to back up its input.
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_STRETCH   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  sorted_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sorted_priority_queue_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_req(req_type_t kind, logic signed [VALUE_W-1:0] value,
                                        logic [PRIO_W-1:0] prio);
    in_item_t r;
    r.req_type      = kind;
    r.item_value    = value;
    r.item_priority = prio;
    return r;
  endfunction

  // Random request; prio_mode picks wide, tied-low, extreme or tied-high priorities
  function automatic in_item_t random_request(int insert_pct, int prio_mode);
    in_item_t r;
    int       pick;
    r.req_type = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       r.item_value = 32'sh7fffffff;
      1:       r.item_value = 32'sh80000000;
      2:       r.item_value = $signed($urandom_range(0, 15)) - 8;
      default: r.item_value = $urandom;
    endcase
    case (prio_mode)
      0:       r.item_priority = PRIO_W'($urandom_range(0, 255));
      1:       r.item_priority = PRIO_W'($urandom_range(0, 3));
      2:       r.item_priority = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: r.item_priority = PRIO_W'($urandom_range(252, 255));
    endcase
    return r;
  endfunction

  // One input transfer; valid stays high across back-to-back items
  task automatic send_request(input in_item_t req, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender
  initial begin : stimulus
    int  sent;
    int  phase_len;
    int  insert_pct;
    int  prio_mode;
    bit  burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty remove, extremes, ties in arrival order
    send_request(make_req(REQ_REMOVE, 32'sd123, 8'd200), pick_gap());
    send_request(make_req(REQ_INSERT, 32'sh7fffffff, 8'd0), pick_gap());
    send_request(make_req(REQ_INSERT, 32'sh80000000, 8'd255), pick_gap());
    send_request(make_req(REQ_INSERT, 32'sd0, 8'd128), pick_gap());
    send_request(make_req(REQ_INSERT, -32'sd1, 8'd128), pick_gap());
    send_request(make_req(REQ_INSERT, 32'sd1, 8'd128), pick_gap());
    send_request(make_req(REQ_INSERT, 32'sd7, 8'd255), pick_gap());
    send_request(make_req(REQ_INSERT, -32'sd5, 8'd0), pick_gap());
    repeat (3) send_request(make_req(REQ_REMOVE, 32'sh7fffffff, 8'hff), pick_gap());
    // Fill to capacity with ties, then one insert too many
    for (int k = 0; k < 12; k++)
      send_request(make_req(REQ_INSERT, 32'sd1000 + k, 8'd128), pick_gap());
    send_request(make_req(REQ_INSERT, 32'sh5a5a5a5a, 8'd255), pick_gap());
    send_request(make_req(REQ_REMOVE, 32'sd0, 8'd0), pick_gap());

    // Random phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      prio_mode = $urandom_range(0, 3);
      burst     = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        send_request(random_request(insert_pct, prio_mode), burst ? 0 : pick_gap());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for pipeline latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: ready stretches and gaps, with one forced long hold-off early on and rare random ones
  initial begin : receiver
    int stretch;
    int ready_len;
    int gap;
    stretch = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      ready_len = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (ready_len) @(posedge clk);
      if (stretch == HOLD_STRETCH || $urandom_range(0, 199) == 0) gap = HOLD_CYCLES;
      else gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      stretch++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
